/* src/clr_pkg.sv */
package clr_pkg;

    // request kinds carried on s_tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // dash pattern is indexed by the low bits of the step count
    localparam int PAT_IDX_BITS = 3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FRAME_BASE  = 3'd0,
        REG_ROW_PITCH   = 3'd1,
        REG_VIEW_LEFT   = 3'd2,
        REG_VIEW_TOP    = 3'd3,
        REG_VIEW_RIGHT  = 3'd4,
        REG_VIEW_BOTTOM = 3'd5
    } cfg_idx_t;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // configuration reset values
    localparam logic [31:0]        RST_FRAME_BASE  = 32'd0;
    localparam logic [15:0]        RST_ROW_PITCH   = 16'd640;
    localparam logic signed [15:0] RST_VIEW_LEFT   = 16'sd0;
    localparam logic signed [15:0] RST_VIEW_TOP    = 16'sd0;
    localparam logic signed [15:0] RST_VIEW_RIGHT  = 16'sd640;
    localparam logic signed [15:0] RST_VIEW_BOTTOM = 16'sd480;

    typedef struct packed {
        logic [31:0]        frame_base;
        logic [15:0]        row_pitch;
        logic signed [15:0] view_left;
        logic signed [15:0] view_top;
        logic signed [15:0] view_right;
        logic signed [15:0] view_bottom;
    } cfg_t;

    // per-pixel status from the stepper to the output stage
    typedef struct packed {
        logic pat_en;  // pattern enables this pixel
        logic last;    // final pixel of the line, or idle
        logic idle;    // step request with no active line
    } pix_flags_t;

endpackage

/* src/clipped_line_rasterizer_top.sv */
// Clipped Bresenham line rasterizer.
// An accepted request reaches m_tvalid through the stepper register, then the clip
// and address register with the row multiply. Throughput: one request and one pixel
// per clock while m_tready is high; the step recurrence has no pipeline register.
// Reset: synchronous active-low aresetn; no line active, view 0..640 x 0..480, pitch 640.
module clipped_line_rasterizer_top
    import clr_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration writes
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    // requests
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // start_x, start_y, end_x, end_y, dash_pattern, line_color
    input  logic [((4*COORD_BITS+40+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic                     s_tuser,
    // pixels
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pix_x, pix_y, pix_addr, pix_color
    output logic [((2*COORD_BITS+64+7)/8)*8-1:0] m_tdata,
    // write_en
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int C          = COORD_BITS;
    localparam int CW         = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int OUT_TDATA  = ((2*COORD_BITS+64+7)/8)*8;

    cfg_t                cfg;
    logic                pix_valid, pix_ready;
    logic signed [C-1:0] pix_x, pix_y;
    logic [31:0]         pix_color;
    pix_flags_t          pix_flags;

    clr_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    clr_stepper #(.COORD_BITS(C)) u_stepper (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_type     (s_tuser),
        .start_x      (signed'(s_tdata[C-1:0])),
        .start_y      (signed'(s_tdata[2*C-1:C])),
        .end_x        (signed'(s_tdata[3*C-1:2*C])),
        .end_y        (signed'(s_tdata[4*C-1:3*C])),
        .dash_pattern (s_tdata[4*C+7:4*C]),
        .line_color   (s_tdata[4*C+39:4*C+8]),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .pix_color    (pix_color),
        .pix_flags    (pix_flags)
    );

    clr_pixel_out #(.COORD_BITS(C), .TDATA_BITS(OUT_TDATA)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_color (pix_color),
        .pix_flags (pix_flags),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // checks
    logic signed [CW-1:0] chk_x, chk_y;
    assign chk_x = CW'(signed'(m_tdata[C-1:0]));
    assign chk_y = CW'(signed'(m_tdata[2*C-1:C]));

    // an enabled write always lands inside the viewport
    a_write_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            chk_x >= CW'(cfg.view_left) && chk_x < CW'(cfg.view_right) &&
            chk_y >= CW'(cfg.view_top)  && chk_y < CW'(cfg.view_bottom))
        else $error("write enabled outside viewport");

    // an idle step pixel is blank and ends the run
    a_idle_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_valid && pix_flags.idle |-> pix_flags.last && !pix_flags.pat_en &&
            pix_x == '0 && pix_y == '0 && pix_color == '0)
        else $error("idle step pixel not blank");

    // a held stepper pixel is not dropped while the output stalls
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_x) && $stable(pix_y))
        else $error("stepper pixel lost under stall");

endmodule

/* src/clr_cfg_regs.sv */
module clr_cfg_regs
    import clr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode; unused indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                REG_FRAME_BASE:  cfg_next.frame_base  = cfg_wr_data;
                REG_ROW_PITCH:   cfg_next.row_pitch   = cfg_wr_data[15:0];
                REG_VIEW_LEFT:   cfg_next.view_left   = signed'(cfg_wr_data[15:0]);
                REG_VIEW_TOP:    cfg_next.view_top    = signed'(cfg_wr_data[15:0]);
                REG_VIEW_RIGHT:  cfg_next.view_right  = signed'(cfg_wr_data[15:0]);
                REG_VIEW_BOTTOM: cfg_next.view_bottom = signed'(cfg_wr_data[15:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base  <= RST_FRAME_BASE;
            cfg_reg.row_pitch   <= RST_ROW_PITCH;
            cfg_reg.view_left   <= RST_VIEW_LEFT;
            cfg_reg.view_top    <= RST_VIEW_TOP;
            cfg_reg.view_right  <= RST_VIEW_RIGHT;
            cfg_reg.view_bottom <= RST_VIEW_BOTTOM;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/clr_stepper.sv */
module clr_stepper
    import clr_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request side
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         req_type,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [7:0]                   dash_pattern,
    input  logic [31:0]                  line_color,
    // pixel toward the output stage
    output logic                         pix_valid,
    input  logic                         pix_ready,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic [31:0]                  pix_color,
    output pix_flags_t                   pix_flags
);

    localparam int C = COORD_BITS;

    // line state
    logic signed [C-1:0] cur_x_reg,   cur_x_next;
    logic signed [C-1:0] cur_y_reg,   cur_y_next;
    logic [C:0]          err_acc_reg, err_acc_next;
    logic [C-1:0]        abs_dx_reg,  abs_dx_next;
    logic [C-1:0]        abs_dy_reg,  abs_dy_next;
    logic signed [1:0]   dir_x_reg,   dir_x_next;
    logic signed [1:0]   dir_y_reg,   dir_y_next;
    logic                x_major_reg, x_major_next;
    logic [C-1:0]        step_reg,    step_next;
    logic [7:0]          pattern_reg, pattern_next;
    logic [31:0]         color_reg,   color_next;
    logic                active_reg,  active_next;

    // result register
    logic                s1_valid_reg, s1_valid_next;
    logic signed [C-1:0] s1_x_reg,     s1_x_next;
    logic signed [C-1:0] s1_y_reg,     s1_y_next;
    logic [31:0]         s1_color_reg, s1_color_next;
    pix_flags_t          s1_flags_reg, s1_flags_next;

    logic accept;

    // start setup
    logic signed [C:0] dx, dy;
    logic [C-1:0]      st_adx, st_ady, st_major;
    logic              st_xmaj;

    // step datapath
    logic [C-1:0]      major, minor;
    logic [C:0]        err_sum;
    logic              carry;
    logic [C-1:0]      step_inc;
    logic signed [C-1:0] dxe, dye;

    assign req_ready = !s1_valid_reg || pix_ready;
    assign accept    = req_valid && req_ready;

    // endpoint deltas, magnitudes and major axis
    always_comb begin
        dx       = (C+1)'(end_x) - (C+1)'(start_x);
        dy       = (C+1)'(end_y) - (C+1)'(start_y);
        st_adx   = dx[C] ? C'(-dx) : C'(dx);
        st_ady   = dy[C] ? C'(-dy) : C'(dy);
        st_xmaj  = st_adx >= st_ady;
        st_major = st_xmaj ? st_adx : st_ady;
    end

    // one Bresenham step: error add, compare, subtract
    always_comb begin
        major    = x_major_reg ? abs_dx_reg : abs_dy_reg;
        minor    = x_major_reg ? abs_dy_reg : abs_dx_reg;
        err_sum  = err_acc_reg + (C+1)'(minor);
        carry    = err_sum >= (C+1)'(major);
        step_inc = step_reg + C'(1);
        dxe      = C'(dir_x_reg);
        dye      = C'(dir_y_reg);
    end

    // next state and pixel
    always_comb begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        err_acc_next  = err_acc_reg;
        abs_dx_next   = abs_dx_reg;
        abs_dy_next   = abs_dy_reg;
        dir_x_next    = dir_x_reg;
        dir_y_next    = dir_y_reg;
        x_major_next  = x_major_reg;
        step_next     = step_reg;
        pattern_next  = pattern_reg;
        color_next    = color_reg;
        active_next   = active_reg;
        s1_x_next     = s1_x_reg;
        s1_y_next     = s1_y_reg;
        s1_color_next = s1_color_reg;
        s1_flags_next = s1_flags_reg;
        s1_valid_next = s1_valid_reg && !pix_ready;

        if (accept) begin
            s1_valid_next = 1'b1;
            if (req_type == REQ_START) begin
                abs_dx_next   = st_adx;
                abs_dy_next   = st_ady;
                dir_x_next    = dx[C] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
                dir_y_next    = dy[C] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
                x_major_next  = st_xmaj;
                err_acc_next  = (C+1)'(st_major >> 1);
                cur_x_next    = start_x;
                cur_y_next    = start_y;
                step_next     = '0;
                pattern_next  = dash_pattern;
                color_next    = line_color;
                active_next   = st_major != '0;
                s1_x_next     = start_x;
                s1_y_next     = start_y;
                s1_color_next = line_color;
                s1_flags_next = '{pat_en: 1'b1, last: st_major == '0, idle: 1'b0};
            end else if (!active_reg) begin
                // step with no line: blank pixel, state untouched
                s1_x_next     = '0;
                s1_y_next     = '0;
                s1_color_next = '0;
                s1_flags_next = '{pat_en: 1'b0, last: 1'b1, idle: 1'b1};
            end else begin
                err_acc_next = carry ? err_sum - (C+1)'(major) : err_sum;
                if (x_major_reg) begin
                    cur_x_next = cur_x_reg + dxe;
                    cur_y_next = carry ? cur_y_reg + dye : cur_y_reg;
                end else begin
                    cur_y_next = cur_y_reg + dye;
                    cur_x_next = carry ? cur_x_reg + dxe : cur_x_reg;
                end
                step_next     = step_inc;
                active_next   = step_inc < major;
                s1_x_next     = cur_x_next;
                s1_y_next     = cur_y_next;
                s1_color_next = color_reg;
                s1_flags_next = '{pat_en: pattern_reg[step_reg[PAT_IDX_BITS-1:0]],
                                  last:   step_inc >= major,
                                  idle:   1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            err_acc_reg  <= '0;
            abs_dx_reg   <= '0;
            abs_dy_reg   <= '0;
            dir_x_reg    <= '0;
            dir_y_reg    <= '0;
            x_major_reg  <= 1'b0;
            step_reg     <= '0;
            pattern_reg  <= '0;
            color_reg    <= '0;
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            err_acc_reg  <= err_acc_next;
            abs_dx_reg   <= abs_dx_next;
            abs_dy_reg   <= abs_dy_next;
            dir_x_reg    <= dir_x_next;
            dir_y_reg    <= dir_y_next;
            x_major_reg  <= x_major_next;
            step_reg     <= step_next;
            pattern_reg  <= pattern_next;
            color_reg    <= color_next;
            active_reg   <= active_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // pixel payload
    always_ff @(posedge aclk) begin
        s1_x_reg     <= s1_x_next;
        s1_y_reg     <= s1_y_next;
        s1_color_reg <= s1_color_next;
        s1_flags_reg <= s1_flags_next;
    end

    assign pix_valid = s1_valid_reg;
    assign pix_x     = s1_x_reg;
    assign pix_y     = s1_y_reg;
    assign pix_color = s1_color_reg;
    assign pix_flags = s1_flags_reg;

endmodule

/* src/clr_pixel_out.sv */
module clr_pixel_out
    import clr_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TDATA_BITS = 96
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    // pixel from the stepper
    input  logic                         pix_valid,
    output logic                         pix_ready,
    input  logic signed [COORD_BITS-1:0] pix_x,
    input  logic signed [COORD_BITS-1:0] pix_y,
    input  logic [31:0]                  pix_color,
    input  pix_flags_t                   pix_flags,
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [TDATA_BITS-1:0]        m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);

    localparam int C  = COORD_BITS;
    localparam int CW = (COORD_BITS > 16) ? COORD_BITS : 16;

    logic                 valid_reg, valid_next;
    logic signed [C-1:0]  x_reg, y_reg;
    logic [31:0]          addr_reg, addr_next;
    logic [31:0]          color_reg;
    logic                 wen_reg, wen_next;
    logic                 last_reg;
    logic                 load;

    logic signed [CW-1:0] cx, cy;
    logic                 in_view;
    logic signed [31:0]   y32, x32;
    logic [31:0]          row_off;

    assign pix_ready  = !valid_reg || m_tready;
    assign load       = pix_valid && pix_ready;
    assign valid_next = pix_ready ? pix_valid : valid_reg;

    // half-open viewport test
    always_comb begin
        cx      = CW'(pix_x);
        cy      = CW'(pix_y);
        in_view = (cx >= CW'(cfg.view_left)) && (cx < CW'(cfg.view_right)) &&
                  (cy >= CW'(cfg.view_top))  && (cy < CW'(cfg.view_bottom));
        wen_next = pix_flags.pat_en && in_view && !pix_flags.idle;
    end

    // frame address, modulo 2^32
    always_comb begin
        y32       = 32'(pix_y);
        x32       = 32'(pix_x);
        row_off   = 32'(unsigned'(y32) * {16'b0, cfg.row_pitch});
        addr_next = pix_flags.idle ? 32'd0
                                   : cfg.frame_base + row_off + unsigned'(x32);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg     <= pix_x;
            y_reg     <= pix_y;
            addr_reg  <= addr_next;
            color_reg <= pix_color;
            wen_reg   <= wen_next;
            last_reg  <= pix_flags.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_BITS'({color_reg, addr_reg, y_reg, x_reg});
    assign m_tuser  = wen_reg;
    assign m_tlast  = last_reg;

endmodule
